@@ rtl/core/phs_pkg.sv @@
package phs_pkg;

    localparam int TABLE_SLOTS = 4096;
    localparam int STACK_DEPTH = 6;
    localparam int N_CALLERS   = 5;
    localparam int FRAME_W     = 48;
    localparam int COUNT_W     = 32;
    localparam int TOTAL_W     = 40;
    localparam int SLOT_W      = 12;
    localparam int USED_W      = 13;
    localparam int DEPTH_W     = 3;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef enum logic [2:0] {
        ST_HIT        = 3'd0,
        ST_INSERTED   = 3'd1,
        ST_DROPPED    = 3'd2,
        ST_IGNORED    = 3'd3,
        ST_READ_OK    = 3'd4,
        ST_READ_EMPTY = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RD_ISSUE,
        S_RD_DATA
    } t_state;

    // key memory word: searched leaf plus its hit count
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [FRAME_W-1:0] leaf;
    } t_key_word;

    // data memory word: stored depth and caller frames
    typedef struct packed {
        logic [DEPTH_W-1:0]                  depth;
        logic [N_CALLERS-1:0][FRAME_W-1:0]   callers;
    } t_data_word;

    typedef struct packed {
        logic                                kind;
        logic [DEPTH_W-1:0]                  frame_depth;
        logic [FRAME_W-1:0]                  leaf;
        logic [N_CALLERS-1:0][FRAME_W-1:0]   callers;
        logic [SLOT_W-1:0]                   read_slot;
    } t_item;

    typedef struct packed {
        t_status                             status;
        logic [SLOT_W-1:0]                   slot_index;
        logic [COUNT_W-1:0]                  hit_count;
        logic [USED_W-1:0]                   slots_used;
        logic [TOTAL_W-1:0]                  total_samples;
        logic [DEPTH_W-1:0]                  stored_depth;
        logic [FRAME_W-1:0]                  leaf;
        logic [N_CALLERS-1:0][FRAME_W-1:0]   callers;
    } t_result;

    typedef struct packed {
        logic                                key_we;
        logic                                data_we;
        logic [SLOT_W-1:0]                   waddr;
        logic [SLOT_W-1:0]                   raddr;
        t_key_word                           key_wdata;
        t_data_word                          data_wdata;
    } t_mem_req;

endpackage

@@ rtl/core/phs_ram.sv @@
module phs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/phs_cfg.sv @@
module phs_cfg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic        o_enable
);

    logic r_enable;
    logic w_write;

    assign pready  = 1'b1;
    assign w_write = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (w_write && paddr[2] == 1'b0) begin
            r_enable <= pwdata[0];
        end
    end

    // only paddr[2] decodes: offsets with it clear hold the enable word, others read zero
    assign prdata   = (paddr[2] == 1'b0) ? {31'd0, r_enable} : 32'd0;
    assign o_enable = r_enable;

endmodule

@@ rtl/core/phs_ctrl.sv @@
module phs_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_enable,
    input  phs_pkg::t_item       i_item,
    input  phs_pkg::t_key_word   i_key_rdata,
    input  phs_pkg::t_data_word  i_data_rdata,
    output phs_pkg::t_mem_req    o_mem,
    output logic                 o_busy,
    output logic                 o_done,
    output phs_pkg::t_result     o_result
);

    import phs_pkg::*;

    t_state                           r_state, n_state;
    logic [USED_W-1:0]                r_addr, n_addr;
    logic                             r_pend, n_pend;
    logic [SLOT_W-1:0]                r_pidx, n_pidx;
    logic [USED_W-1:0]                r_used, n_used;
    logic [TOTAL_W-1:0]               r_total, n_total;
    logic                             r_done, n_done;
    t_result                          r_res, n_res;

    logic [FRAME_W-1:0]               r_leaf;
    logic [DEPTH_W-1:0]               r_depth;
    logic [N_CALLERS-1:0][FRAME_W-1:0] r_callers;
    logic [SLOT_W-1:0]                r_rslot;

    logic                             w_accept;
    logic [DEPTH_W-1:0]               w_depth_sat;

    assign w_accept    = i_start && (r_state == S_IDLE);
    assign w_depth_sat = (i_item.frame_depth > DEPTH_W'(STACK_DEPTH)) ?
                         DEPTH_W'(STACK_DEPTH) : i_item.frame_depth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr  <= '0;
            r_pend  <= 1'b0;
            r_pidx  <= '0;
            r_used  <= '0;
            r_total <= '0;
            r_done  <= 1'b0;
        end else begin
            r_addr  <= n_addr;
            r_pend  <= n_pend;
            r_pidx  <= n_pidx;
            r_used  <= n_used;
            r_total <= n_total;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (w_accept) begin
            r_leaf    <= i_item.leaf;
            r_depth   <= w_depth_sat;
            r_callers <= i_item.callers;
            r_rslot   <= i_item.read_slot;
        end
    end

    always_comb begin
        logic w_match;
        n_state = r_state;
        n_addr  = r_addr;
        n_pend  = 1'b0;
        n_pidx  = r_pidx;
        n_used  = r_used;
        n_total = r_total;
        n_done  = 1'b0;
        n_res   = r_res;

        o_mem                    = '0;
        o_mem.raddr              = r_addr[SLOT_W-1:0];
        o_mem.key_wdata.leaf     = r_leaf;
        o_mem.key_wdata.count    = COUNT_W'(1);
        o_mem.data_wdata.depth   = r_depth;
        for (int i = 0; i < N_CALLERS; i++) begin
            o_mem.data_wdata.callers[i] =
                (r_depth > DEPTH_W'(i + 1)) ? r_callers[i] : '0;
        end

        w_match = r_pend && (i_key_rdata.leaf == r_leaf);

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_item.kind == KIND_READ) begin
                        if (USED_W'(i_item.read_slot) < r_used) begin
                            n_state = S_RD_ISSUE;
                        end else begin
                            n_done       = 1'b1;
                            n_res        = '0;
                            n_res.status = ST_READ_EMPTY;
                        end
                    end else if (!i_enable || i_item.frame_depth == '0) begin
                        n_done       = 1'b1;
                        n_res        = '0;
                        n_res.status = ST_IGNORED;
                    end else begin
                        if (r_total != '1) begin
                            n_total = r_total + TOTAL_W'(1);
                        end
                        n_addr  = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (w_match) begin
                    // hit: bump the count in place and finish
                    o_mem.key_we          = 1'b1;
                    o_mem.waddr           = r_pidx;
                    o_mem.key_wdata.count = (i_key_rdata.count != '1) ?
                                            i_key_rdata.count + COUNT_W'(1) :
                                            i_key_rdata.count;
                    n_done           = 1'b1;
                    n_res            = '0;
                    n_res.status     = ST_HIT;
                    n_res.slot_index = r_pidx;
                    n_res.hit_count  = o_mem.key_wdata.count;
                    n_state          = S_IDLE;
                end else if (r_addr < r_used) begin
                    // issue the next key read, compare it next cycle
                    n_pend = 1'b1;
                    n_pidx = r_addr[SLOT_W-1:0];
                    n_addr = r_addr + USED_W'(1);
                end else begin
                    n_done  = 1'b1;
                    n_res   = '0;
                    n_state = S_IDLE;
                    if (r_used >= USED_W'(TABLE_SLOTS)) begin
                        n_res.status = ST_DROPPED;
                    end else begin
                        o_mem.key_we     = 1'b1;
                        o_mem.data_we    = 1'b1;
                        o_mem.waddr      = r_used[SLOT_W-1:0];
                        n_used           = r_used + USED_W'(1);
                        n_res.status     = ST_INSERTED;
                        n_res.slot_index = r_used[SLOT_W-1:0];
                        n_res.hit_count  = COUNT_W'(1);
                    end
                end
            end
            S_RD_ISSUE: begin
                o_mem.raddr = r_rslot;
                n_state     = S_RD_DATA;
            end
            S_RD_DATA: begin
                n_done             = 1'b1;
                n_res              = '0;
                n_res.status       = ST_READ_OK;
                n_res.slot_index   = r_rslot;
                n_res.hit_count    = i_key_rdata.count;
                n_res.stored_depth = i_data_rdata.depth;
                n_res.leaf         = (i_data_rdata.depth != '0) ? i_key_rdata.leaf : '0;
                for (int i = 0; i < N_CALLERS; i++) begin
                    n_res.callers[i] = (i_data_rdata.depth > DEPTH_W'(i + 1)) ?
                                       i_data_rdata.callers[i] : '0;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (n_done) begin
            n_res.slots_used    = n_used;
            n_res.total_samples = n_total;
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

@@ rtl/core/pc_sample_histogram_top.sv @@
// PC sample histogram. An item is taken when start is high and busy is low;
// its single result appears on the o_ result ports, which hold it until the
// next result, marked by o_done for exactly one cycle in the cycle after the
// item finishes; it cannot be held off by the receiver. A sample with enable
// clear or depth zero, and a read of a slot at or past the used count, finish
// at once (result in the cycle after the accept, busy never rises). A recorded
// sample scans the used slots one key-memory read per cycle: a hit stops the
// scan and bumps that slot's count, a miss scans every used slot and then
// inserts, or drops the sample if the table is full. The table memories
// need no clearing after reset: only slots below the used count are ever
// compared or returned. Write enable over APB (offset 0, bit 0) only while
// idle; reads ignore it.
module pc_sample_histogram_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic        i_kind,
    input  logic [2:0]  i_frame_depth,
    input  logic [47:0] i_leaf_frame,
    input  logic [47:0] i_caller_frame_1,
    input  logic [47:0] i_caller_frame_2,
    input  logic [47:0] i_caller_frame_3,
    input  logic [47:0] i_caller_frame_4,
    input  logic [47:0] i_caller_frame_5,
    input  logic [11:0] i_read_slot,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [11:0] o_slot_index,
    output logic [31:0] o_hit_count,
    output logic [12:0] o_slots_used,
    output logic [39:0] o_total_samples,
    output logic [2:0]  o_stored_depth,
    output logic [47:0] o_out_leaf,
    output logic [47:0] o_out_caller_1,
    output logic [47:0] o_out_caller_2,
    output logic [47:0] o_out_caller_3,
    output logic [47:0] o_out_caller_4,
    output logic [47:0] o_out_caller_5
);

    import phs_pkg::*;

    logic       w_enable;
    t_item      w_item;
    t_mem_req   w_mem;
    t_key_word  w_key_rdata;
    t_data_word w_data_rdata;
    t_result    w_res;

    // register file: enable bit
    phs_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_enable (w_enable)
    );

    // gather the item fields
    assign w_item.kind        = i_kind;
    assign w_item.frame_depth = i_frame_depth;
    assign w_item.leaf        = i_leaf_frame;
    assign w_item.callers[0]  = i_caller_frame_1;
    assign w_item.callers[1]  = i_caller_frame_2;
    assign w_item.callers[2]  = i_caller_frame_3;
    assign w_item.callers[3]  = i_caller_frame_4;
    assign w_item.callers[4]  = i_caller_frame_5;
    assign w_item.read_slot   = i_read_slot;

    // sequencer: scan, read-modify-write of the count, insert, slot read.
    // busy stays high until the write-back edge, so no later read can
    // overlap a pending write to the same slot.
    phs_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_enable     (w_enable),
        .i_item       (w_item),
        .i_key_rdata  (w_key_rdata),
        .i_data_rdata (w_data_rdata),
        .o_mem        (w_mem),
        .o_busy       (busy),
        .o_done       (o_done),
        .o_result     (w_res)
    );

    // key memory: leaf and count, read every scan cycle
    phs_ram #(
        .WIDTH ($bits(t_key_word)),
        .DEPTH (TABLE_SLOTS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.key_we),
        .i_waddr (w_mem.waddr),
        .i_wdata (w_mem.key_wdata),
        .i_raddr (w_mem.raddr),
        .o_rdata (w_key_rdata)
    );

    // data memory: depth and callers, written on insert, read on slot reads
    phs_ram #(
        .WIDTH ($bits(t_data_word)),
        .DEPTH (TABLE_SLOTS)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.data_we),
        .i_waddr (w_mem.waddr),
        .i_wdata (w_mem.data_wdata),
        .i_raddr (w_mem.raddr),
        .o_rdata (w_data_rdata)
    );

    // spread the result item over its ports
    assign o_status        = w_res.status;
    assign o_slot_index    = w_res.slot_index;
    assign o_hit_count     = w_res.hit_count;
    assign o_slots_used    = w_res.slots_used;
    assign o_total_samples = w_res.total_samples;
    assign o_stored_depth  = w_res.stored_depth;
    assign o_out_leaf      = w_res.leaf;
    assign o_out_caller_1  = w_res.callers[0];
    assign o_out_caller_2  = w_res.callers[1];
    assign o_out_caller_3  = w_res.callers[2];
    assign o_out_caller_4  = w_res.callers[3];
    assign o_out_caller_5  = w_res.callers[4];

endmodule
